### src/radix_integer_text_parser_top_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the radix integer text parser
// ---------------------------------------------------------------------------
`ifndef RADIX_INTEGER_TEXT_PARSER_TOP_MACROS_SVH
`define RADIX_INTEGER_TEXT_PARSER_TOP_MACROS_SVH

// same-cycle implication
`define RIP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("radix parser check failed");

// next-cycle implication
`define RIP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("radix parser check failed");

`endif

### src/rip_pkg.sv
// ---------------------------------------------------------------------------
// rip_pkg
// Shared types, constants and the character classifier of the radix parser.
// ---------------------------------------------------------------------------
package rip_pkg;

	localparam int ACC_WIDTH   = 64;
	localparam int VALUE_WIDTH = 64;
	localparam int RADIX_WIDTH = 6;
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

	localparam logic [ACC_WIDTH-1:0]   MAG_LIMIT = {1'b0, {(ACC_WIDTH-1){1'b1}}};
	localparam logic [VALUE_WIDTH-1:0] SAT_VALUE = VALUE_WIDTH'(MAG_LIMIT);

	localparam logic [RADIX_WIDTH-1:0] RADIX_AUTO = 6'd0;
	localparam logic [RADIX_WIDTH-1:0] RADIX_MIN  = 6'd2;
	localparam logic [RADIX_WIDTH-1:0] RADIX_MAX  = 6'd36;
	localparam logic [RADIX_WIDTH-1:0] RADIX_DEC  = 6'd10;
	localparam logic [RADIX_WIDTH-1:0] RADIX_HEX  = 6'd16;
	localparam logic [RADIX_WIDTH-1:0] NO_DIGIT   = 6'd36;

	localparam logic [1:0] ST_OK  = 2'd0;
	localparam logic [1:0] ST_NAN = 2'd1;
	localparam logic [1:0] ST_SAT = 2'd2;

	typedef struct packed {
		logic [7:0] char_code;
		logic       last_char;
	} char_item_t;

	typedef struct packed {
		logic signed [VALUE_WIDTH-1:0] parsed_value;
		logic [1:0]                    status;
	} result_t;

	typedef struct packed {
		logic                   last_char;
		logic                   is_space;
		logic                   is_minus;
		logic                   is_plus;
		logic                   is_zero;
		logic                   is_x;
		logic [RADIX_WIDTH-1:0] digit;
	} cls_item_t;

	// digit value 0..35, NO_DIGIT otherwise
	function automatic logic [RADIX_WIDTH-1:0] digit_of(input logic [7:0] c);
		logic [RADIX_WIDTH-1:0] d;
		d = NO_DIGIT;
		if (c >= 8'h30 && c <= 8'h39) begin
			d = RADIX_WIDTH'(c - 8'h30);
		end else if (c >= 8'h61 && c <= 8'h7a) begin
			d = RADIX_WIDTH'(c - 8'h61) + RADIX_DEC;
		end else if (c >= 8'h41 && c <= 8'h5a) begin
			d = RADIX_WIDTH'(c - 8'h41) + RADIX_DEC;
		end
		return d;
	endfunction

	function automatic cls_item_t classify(input char_item_t it);
		cls_item_t r;
		r.last_char = it.last_char;
		r.is_space  = (it.char_code == 8'h20) ||
		              (it.char_code >= 8'h09 && it.char_code <= 8'h0d);
		r.is_minus  = (it.char_code == 8'h2d);
		r.is_plus   = (it.char_code == 8'h2b);
		r.is_zero   = (it.char_code == 8'h30);
		r.is_x      = (it.char_code == 8'h78) || (it.char_code == 8'h58);
		r.digit     = digit_of(it.char_code);
		return r;
	endfunction

endpackage

### src/radix_integer_text_parser_top.sv
// A last byte passes the front register and the queue, then its result register.
// Throughput: one byte per cycle unless a result stalls; the back stage's digit
//   multiply-accumulate (magnitude times radix plus digit) sets this.
// A 4-entry queue decouples the classifier front from the parse back end.
// Reset (arst_n low): radix_mode to auto, parse state to leading whitespace,
//   queue and result empty; no clearing pass.
// ---------------------------------------------------------------------------
// radix_integer_text_parser_top
// Streaming integer text parser with auto or fixed radix and saturation.
// ---------------------------------------------------------------------------
module radix_integer_text_parser_top import rip_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   char_valid,
	output logic                   char_stall,
	input  char_item_t             char_data,
	output logic                   result_valid,
	input  logic                   result_stall,
	output result_t                result_data,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [RADIX_WIDTH-1:0] cfg_data
);

	logic [RADIX_WIDTH-1:0] radix_mode_q;
	logic                   push, queue_full, pop, head_valid;
	cls_item_t              push_data, head_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_mode_q <= RADIX_AUTO;
		end else if (cfg_valid && cfg_ready) begin
			radix_mode_q <= cfg_data;
		end
	end

	rip_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_data  (char_data),
		.push       (push),
		.push_data  (push_data),
		.queue_full (queue_full)
	);

	rip_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.full       (queue_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_data  (head_data)
	);

	rip_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.radix_mode   (radix_mode_q),
		.head_valid   (head_valid),
		.head_data    (head_data),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_data  (result_data)
	);

endmodule

### src/rip_front.sv
// ---------------------------------------------------------------------------
// rip_front
// Accepts input bytes and registers their classification for the queue.
// ---------------------------------------------------------------------------
module rip_front import rip_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       char_valid,
	output logic       char_stall,
	input  char_item_t char_data,
	output logic       push,
	output cls_item_t  push_data,
	input  logic       queue_full
);

	logic      valid_s1;
	cls_item_t item_s1;

	assign char_stall = valid_s1 && queue_full;
	assign push       = valid_s1 && !queue_full;
	assign push_data  = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (char_valid && !char_stall) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (char_valid && !char_stall) begin
			item_s1 <= classify(char_data);
		end
	end

endmodule

### src/rip_queue.sv
// ---------------------------------------------------------------------------
// rip_queue
// Short FIFO of classified bytes between front and back.
// ---------------------------------------------------------------------------
module rip_queue import rip_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  cls_item_t push_data,
	output logic      full,
	input  logic      pop,
	output logic      head_valid,
	output cls_item_t head_data
);

	cls_item_t             mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0]   wr_ptr_q;
	logic [QUEUE_AW-1:0]   rd_ptr_q;
	logic [QUEUE_CW-1:0]   count_q;

	assign full       = (count_q == QUEUE_CW'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

### src/rip_back.sv
// ---------------------------------------------------------------------------
// rip_back
// Parse state machine with digit multiply-accumulate and result register.
// ---------------------------------------------------------------------------
module rip_back import rip_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [RADIX_WIDTH-1:0] radix_mode,
	input  logic                   head_valid,
	input  cls_item_t              head_data,
	output logic                   pop,
	output logic                   result_valid,
	input  logic                   result_stall,
	output result_t                result_data
);

	typedef enum logic [2:0] {
		PH_WS,
		PH_SIGN,
		PH_PREFIX,
		PH_DIGITS,
		PH_DONE,
		PH_BAD
	} phase_t;

	localparam int MAC_W = ACC_WIDTH + RADIX_WIDTH + 1;

	phase_t                 phase_q, phase_n;
	logic                   neg_q, neg_n;
	logic [RADIX_WIDTH-1:0] rad_q, rad_n;
	logic [ACC_WIDTH-1:0]   mag_q, mag_n;
	logic                   sat_q, sat_n;
	logic                   first, do_dig;
	logic [MAC_W-1:0]       mac;
	logic                   out_free;
	logic                   bad_radix;
	logic [VALUE_WIDTH-1:0] mag_ext;
	result_t                res;

	assign out_free  = !result_valid || !result_stall;
	assign pop       = head_valid && (!head_data.last_char || out_free);
	assign bad_radix = (radix_mode != RADIX_AUTO) &&
	                   ((radix_mode < RADIX_MIN) || (radix_mode > RADIX_MAX));

	always_comb begin
		phase_n = phase_q;
		neg_n   = neg_q;
		rad_n   = rad_q;
		sat_n   = sat_q;
		mag_n   = mag_q;
		first   = 1'b0;
		do_dig  = 1'b0;
		unique case (phase_q)
			PH_WS: begin
				if (!head_data.is_space) begin
					if (bad_radix) begin
						phase_n = PH_BAD;
					end else begin
						rad_n = radix_mode;
						if (head_data.is_minus) begin
							neg_n   = 1'b1;
							phase_n = PH_SIGN;
						end else if (head_data.is_plus) begin
							phase_n = PH_SIGN;
						end else begin
							first = 1'b1;
						end
					end
				end
			end
			PH_SIGN: begin
				first = 1'b1;
			end
			PH_PREFIX: begin
				phase_n = PH_DIGITS;
				if (head_data.is_x) begin
					rad_n = RADIX_HEX;
				end else begin
					if (rad_n == RADIX_AUTO) begin
						rad_n = RADIX_DEC;
					end
					do_dig = 1'b1;
				end
			end
			PH_DIGITS: begin
				do_dig = 1'b1;
			end
			default: begin
			end
		endcase

		// first byte after the optional sign: a '0' may open a hex prefix
		if (first) begin
			if (head_data.is_zero && (rad_n == RADIX_AUTO || rad_n == RADIX_HEX)) begin
				phase_n = PH_PREFIX;
			end else begin
				if (rad_n == RADIX_AUTO) begin
					rad_n = RADIX_DEC;
				end
				phase_n = PH_DIGITS;
				do_dig  = 1'b1;
			end
		end

		mac = {{(RADIX_WIDTH+1){1'b0}}, mag_q} * {{(ACC_WIDTH+1){1'b0}}, rad_n}
		      + MAC_W'(head_data.digit);

		if (do_dig) begin
			if (rad_n < RADIX_MIN || head_data.digit >= rad_n) begin
				phase_n = PH_DONE;
			end else if (mac > MAC_W'(MAG_LIMIT)) begin
				mag_n = MAG_LIMIT;
				sat_n = 1'b1;
			end else begin
				mag_n = mac[ACC_WIDTH-1:0];
			end
		end

		mag_ext = VALUE_WIDTH'(mag_n);
		if (phase_n == PH_WS || phase_n == PH_BAD) begin
			res.parsed_value = '0;
			res.status       = ST_NAN;
		end else begin
			res.parsed_value = neg_n ? -mag_ext : mag_ext;
			res.status       = sat_n ? ST_SAT : ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_WS;
			neg_q        <= 1'b0;
			rad_q        <= RADIX_AUTO;
			mag_q        <= '0;
			sat_q        <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			if (pop && head_data.last_char) begin
				phase_q      <= PH_WS;
				neg_q        <= 1'b0;
				rad_q        <= RADIX_AUTO;
				mag_q        <= '0;
				sat_q        <= 1'b0;
				result_valid <= 1'b1;
			end else begin
				if (pop) begin
					phase_q <= phase_n;
					neg_q   <= neg_n;
					rad_q   <= rad_n;
					mag_q   <= mag_n;
					sat_q   <= sat_n;
				end
				if (!result_stall) begin
					result_valid <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head_data.last_char) begin
			result_data <= res;
		end
	end

endmodule

### src/rip_checker.sv
// ---------------------------------------------------------------------------
// rip_checker
// Port-level checks on the parser result stream.
// ---------------------------------------------------------------------------
`include "radix_integer_text_parser_top_macros.svh"

module rip_checker import rip_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    result_valid,
	input  logic    result_stall,
	input  result_t result_data
);

	// a stalled result stays put
	`RIP_ASSERT_NEXT(a_result_hold, clk, arst_n, result_valid && result_stall, result_valid && $stable(result_data))

	`RIP_ASSERT_NOW(a_status_code, clk, arst_n, result_valid, result_data.status == ST_OK || result_data.status == ST_NAN || result_data.status == ST_SAT)

	// NaN always carries a zero value
	`RIP_ASSERT_NOW(a_nan_zero, clk, arst_n, result_valid && result_data.status == ST_NAN, result_data.parsed_value == '0)

	// saturation pins the magnitude at the limit
	`RIP_ASSERT_NOW(a_sat_limit, clk, arst_n, result_valid && result_data.status == ST_SAT, result_data.parsed_value == SAT_VALUE || result_data.parsed_value == -SAT_VALUE)

endmodule

bind radix_integer_text_parser_top rip_checker u_checker (.*);
